// ===== hw/rtl/tmcm_pkg.sv =====
// Shared types and constants for the trace message coverage map.
package tmcm_pkg;

	localparam int MAP_BITS_DEFAULT = 16;
	localparam int CFG_W            = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
	localparam int OUT_DEPTH        = 4;
	localparam int ID_W             = 32;
	localparam int ASM_W            = 24;

	localparam logic [7:0] CODE_TRACE     = 8'h03;
	localparam logic [7:0] CODE_END_OK    = 8'hfd;
	localparam logic [7:0] CODE_END_CRASH = 8'hfe;
	localparam logic [7:0] CODE_QUERY     = 8'hfc;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_OK      = 3'd1,
		ST_CRASH   = 3'd2,
		ST_ERROR   = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_DONE = 2'd0,
		PH_CODE = 2'd1,
		PH_ID   = 2'd2,
		PH_LOC  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		MSG_TRACE = 2'd0,
		MSG_OK    = 2'd1,
		MSG_CRASH = 2'd2
	} msg_t;

	typedef enum logic [1:0] {
		OP_NONE       = 2'd0,
		OP_INCR       = 2'd1,
		OP_READ       = 2'd2,
		OP_READ_CLEAR = 2'd3
	} map_op_t;

	typedef struct packed {
		status_t status;
		map_op_t op;
	} parse_res_t;

	typedef struct packed {
		logic [7:0] value;
		status_t    status;
	} out_item_t;

endpackage

// ===== hw/rtl/tmcm_parser.sv =====
// Message parser, sample id tracking and location hashing for the coverage map.
module tmcm_parser #(
	parameter int MAP_BITS = tmcm_pkg::MAP_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  tmcm_pkg::cmd_t                 command,
	input  logic [7:0]                     link_byte,
	input  logic [15:0]                    map_index,
	input  logic                           clear_after_read,
	input  logic [tmcm_pkg::CFG_W-1:0]     index_bits,
	output tmcm_pkg::parse_res_t           result,
	output logic [MAP_BITS-1:0]            map_addr
);
	import tmcm_pkg::*;

	localparam int H_W = 40;

	phase_t             phase_q, phase_d;
	logic [1:0]         pos_q, pos_d;
	msg_t               msg_q, msg_d;
	logic [ASM_W-1:0]   asm_q, asm_d;
	logic [ID_W-1:0]    exp_id_q, exp_id_d;
	logic [ID_W-1:0]    rx_id_q, rx_id_d;
	logic [MAP_BITS-1:0] prev_q, prev_d;

	logic [ID_W-1:0]     word;
	logic [H_W-1:0]      hash;
	logic [MAP_BITS-1:0] mask;
	logic [MAP_BITS-1:0] hash_index;
	logic                code_known;

	assign word       = {link_byte, asm_q};
	assign hash       = {12'b0, word[ID_W-1:4]} ^ {word, 8'b0};
	assign hash_index = (hash[MAP_BITS-1:0] ^ prev_q) & mask;
	assign code_known = (link_byte == CODE_TRACE) || (link_byte == CODE_END_OK) ||
		(link_byte == CODE_END_CRASH);

	always_comb begin
		for (int i = 0; i < MAP_BITS; i++) begin
			mask[i] = (index_bits > CFG_W'(i));
		end
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		msg_d    = msg_q;
		asm_d    = asm_q;
		exp_id_d = exp_id_q;
		rx_id_d  = rx_id_q;
		prev_d   = prev_q;
		if (item_valid) begin
			unique case (command)
				CMD_START: begin
					exp_id_d = exp_id_q + 1'b1;
					prev_d   = '0;
					rx_id_d  = '0;
					phase_d  = PH_CODE;
					pos_d    = '0;
					msg_d    = MSG_TRACE;
					asm_d    = '0;
				end
				CMD_BYTE: begin
					unique case (phase_q)
						PH_CODE: begin
							if (code_known) begin
								phase_d = PH_ID;
								pos_d   = '0;
								asm_d   = '0;
								priority if (link_byte == CODE_TRACE) msg_d = MSG_TRACE;
								else if (link_byte == CODE_END_OK) msg_d = MSG_OK;
								else msg_d = MSG_CRASH;
							end else begin
								phase_d = PH_DONE;
							end
						end
						PH_ID, PH_LOC: begin
							if (pos_q != 2'd3) begin
								pos_d = pos_q + 1'b1;
								unique case (pos_q)
									2'd0: asm_d[7:0]   = link_byte;
									2'd1: asm_d[15:8]  = link_byte;
									default: asm_d[23:16] = link_byte;
								endcase
							end else begin
								pos_d = '0;
								asm_d = '0;
								if (phase_q == PH_LOC) begin
									prev_d  = hash[MAP_BITS:1];
									phase_d = PH_CODE;
								end else begin
									rx_id_d = word;
									if (word != exp_id_q || msg_q != MSG_TRACE) begin
										phase_d = PH_DONE;
									end else begin
										phase_d = PH_LOC;
									end
								end
							end
						end
						PH_DONE: begin
						end
					endcase
				end
				CMD_READ, CMD_NONE: begin
				end
			endcase
		end
	end

	always_comb begin
		result.status = ST_NONE;
		result.op     = OP_NONE;
		map_addr      = MAP_BITS'(map_index);
		if (item_valid) begin
			unique case (command)
				CMD_BYTE: begin
					unique case (phase_q)
						PH_CODE: begin
							if (!code_known) begin
								if (link_byte == CODE_QUERY && rx_id_q != exp_id_q) begin
									result.status = ST_ERROR;
								end else begin
									result.status = ST_UNKNOWN;
								end
							end
						end
						PH_ID: begin
							if (pos_q == 2'd3) begin
								priority if (word != exp_id_q) result.status = ST_ERROR;
								else if (msg_q == MSG_OK) result.status = ST_OK;
								else if (msg_q == MSG_CRASH) result.status = ST_CRASH;
								else result.status = ST_NONE;
							end
						end
						PH_LOC: begin
							if (pos_q == 2'd3) begin
								result.op = OP_INCR;
								map_addr  = hash_index;
							end
						end
						PH_DONE: begin
						end
					endcase
				end
				CMD_READ: begin
					result.op = clear_after_read ? OP_READ_CLEAR : OP_READ;
				end
				CMD_START, CMD_NONE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DONE;
			pos_q    <= '0;
			msg_q    <= MSG_TRACE;
			asm_q    <= '0;
			exp_id_q <= '0;
			rx_id_q  <= '0;
			prev_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			msg_q    <= msg_d;
			asm_q    <= asm_d;
			exp_id_q <= exp_id_d;
			rx_id_q  <= rx_id_d;
			prev_q   <= prev_d;
		end
	end

	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE || phase_q == PH_CODE) |-> pos_q == 2'd0)
		else $error("Byte position is nonzero outside an id or location field.");

	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && command == CMD_START |=> phase_q == PH_CODE && pos_q == 2'd0)
		else $error("A sample start did not rearm the parser.");

	a_end_from_id: assert property (@(posedge clk) disable iff (!arst_n)
		(result.status == ST_OK || result.status == ST_CRASH) |->
		phase_q == PH_ID && pos_q == 2'd3 && word == exp_id_q)
		else $error("An exchange ended without a matching id.");

	a_incr_from_loc: assert property (@(posedge clk) disable iff (!arst_n)
		result.op == OP_INCR |=> phase_q == PH_CODE)
		else $error("A map update did not return the parser to the code byte.");

endmodule

// ===== hw/rtl/tmcm_map.sv =====
// Coverage counter memory with increment, read and clear, and the clearing pass after reset.
module tmcm_map #(
	parameter int MAP_BITS = tmcm_pkg::MAP_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tmcm_pkg::map_op_t   op,
	input  logic [MAP_BITS-1:0] addr,
	output logic [7:0]          value,
	output logic                busy
);
	import tmcm_pkg::*;

	localparam int DEPTH = 2 ** MAP_BITS;

	logic [7:0] mem [DEPTH];

	map_op_t             op_s2;
	logic [MAP_BITS-1:0] addr_s2;
	logic [7:0]          rd_s2;

	logic                fwd_en_q;
	logic [MAP_BITS-1:0] fwd_addr_q;
	logic [7:0]          fwd_data_q;

	logic                clr_busy_q;
	logic [MAP_BITS-1:0] clr_addr_q;

	logic [7:0]          cur;
	logic                we_s2;
	logic [7:0]          wd_s2;
	logic                mem_we;
	logic [MAP_BITS-1:0] mem_wa;
	logic [7:0]          mem_wd;

	assign busy = clr_busy_q;
	assign cur  = (fwd_en_q && fwd_addr_q == addr_s2) ? fwd_data_q : rd_s2;

	always_comb begin
		we_s2 = 1'b0;
		wd_s2 = '0;
		value = '0;
		unique case (op_s2)
			OP_INCR: begin
				we_s2 = 1'b1;
				wd_s2 = cur + 8'd1;
			end
			OP_READ: begin
				value = cur;
			end
			OP_READ_CLEAR: begin
				value = cur;
				we_s2 = 1'b1;
			end
			OP_NONE: begin
			end
		endcase
	end

	assign mem_we = clr_busy_q | we_s2;
	assign mem_wa = clr_busy_q ? clr_addr_q : addr_s2;
	assign mem_wd = clr_busy_q ? 8'h00 : wd_s2;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s2 <= mem[addr];
	end

	always_ff @(posedge clk) begin
		addr_s2    <= addr;
		fwd_addr_q <= addr_s2;
		fwd_data_q <= wd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2      <= OP_NONE;
			fwd_en_q   <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			op_s2    <= op;
			fwd_en_q <= we_s2;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	a_no_op_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> op == OP_NONE)
		else $error("A map request arrived during the clearing pass.");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_addr_q) == '1)
		else $error("The clearing pass ended before the last counter.");

	a_read_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		op_s2 == OP_READ_CLEAR ##1
		(op_s2 == OP_READ || op_s2 == OP_READ_CLEAR) && addr_s2 == $past(addr_s2)
		|-> value == 8'h00)
		else $error("A counter read right after its clear did not return zero.");

endmodule

// ===== hw/rtl/trace_message_coverage_map.sv =====
// Top level of the trace message coverage map: input stage, configuration and result queue.
//
// Input transfers arrive on s_axis: tuser holds the command (start sample, link byte,
// counter read), tdata the link byte, the counter address and the clear-after-read flag.
// Every input transfer produces exactly one result transfer on m_axis, in order, with
// the status and the counter value. The cfg channel writes the index width register
// and is always ready; write it only while no transfer is in flight.
// A transfer is registered, parsed and hashed in the first stage, which also issues the
// counter memory read; the second stage updates the counter and pushes the result into
// a four entry queue. A result is offered on m_axis once it has been written into the
// queue, and one input transfer is taken every cycle while the receiver keeps up.
// When the receiver stalls, up to four results are held in the pipeline and queue
// before s_axis_tready drops; it rises again in the cycle after a result leaves.
// After reset the counter memory is cleared one entry per cycle, from the first to the last
// entry; s_axis_tready stays low until the pass is done.
module trace_message_coverage_map #(
	parameter int MAP_BITS = tmcm_pkg::MAP_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// link_byte [7:0], map_index [23:8], clear_after_read [24], zero [31:25]
	input  logic [31:0]                s_axis_tdata,
	// command [1:0]
	input  logic [1:0]                 s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status [2:0], counter_value [10:3], zero [15:11]
	output logic [15:0]                m_axis_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tmcm_pkg::CFG_W-1:0] cfg_data
);
	import tmcm_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	logic [CFG_W-1:0] index_bits_q;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [7:0]  byte_s1;
	logic [15:0] index_s1;
	logic        clear_s1;

	logic        valid_s2;
	status_t     status_s2;

	parse_res_t          parse_res;
	logic [MAP_BITS-1:0] map_addr;
	logic [7:0]          value_s2;
	logic                map_busy;

	out_item_t         fifo_q [OUT_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W:0]    occupancy;
	logic              in_xfer;
	logic              out_xfer;
	out_item_t         out_item;

	assign cfg_ready = 1'b1;
	assign occupancy = (CNT_W + 1)'(count_q) + (CNT_W + 1)'(valid_s1) +
		(CNT_W + 1)'(valid_s2);
	assign s_axis_tready = !map_busy && (occupancy < (CNT_W + 1)'(OUT_DEPTH));
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	assign m_axis_tvalid = (count_q != '0);
	assign out_item      = fifo_q[rd_ptr_q];
	assign m_axis_tdata  = {5'b0, out_item};

	tmcm_parser #(
		.MAP_BITS(MAP_BITS)
	) u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (valid_s1),
		.command          (cmd_s1),
		.link_byte        (byte_s1),
		.map_index        (index_s1),
		.clear_after_read (clear_s1),
		.index_bits       (index_bits_q),
		.result           (parse_res),
		.map_addr         (map_addr)
	);

	tmcm_map #(
		.MAP_BITS(MAP_BITS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (parse_res.op),
		.addr   (map_addr),
		.value  (value_s2),
		.busy   (map_busy)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1   <= cmd_t'(s_axis_tuser);
			byte_s1  <= s_axis_tdata[7:0];
			index_s1 <= s_axis_tdata[23:8];
			clear_s1 <= s_axis_tdata[24];
		end
		status_s2 <= parse_res.status;
		if (valid_s2) begin
			fifo_q[wr_ptr_q] <= '{value: value_s2, status: status_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= CFG_RESET;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				index_bits_q <= cfg_data;
			end
			valid_s1 <= in_xfer;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(valid_s2) - CNT_W'(out_xfer);
		end
	end

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (CNT_W + 1)'(OUT_DEPTH))
		else $error("More transfers in flight than the result queue can hold.");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> count_q < CNT_W'(OUT_DEPTH))
		else $error("A result was pushed into a full queue.");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		map_busy |-> !s_axis_tready)
		else $error("An input transfer was offered room during the clearing pass.");

endmodule
